// ===== rtl/als_agr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_agr_pkg - shared definitions for light sensor auto gain ranging
// Field widths, reset values, threshold record and gain code look-ups.
// ----------------------------------------------------------------------------
package als_agr_pkg;

   // Field widths
   localparam int COUNT_W     = 16;
   localparam int STEP_W      = 3;
   localparam int CODE_LOW_W  = 2;
   localparam int CODE_HIGH_W = 5;
   localparam int INTEG_W     = 8;

   // Integration setting after reset, and the last setting that keeps the
   // full scale uncapped (also the limit for the lower saturation threshold)
   localparam logic [INTEG_W-1:0] INTEG_RESET = 8'd63;
   localparam logic [INTEG_W-1:0] INTEG_LIMIT = 8'd63;

   localparam int GAIN_STEPS_DEFAULT = 6;
   localparam int RESET_STEP_NOMINAL = 3;

   // floor(x / 20) = (x * RECIP20) >> RECIP20_SHIFT, exact for x < 2^18
   localparam int              RECIP20_SHIFT = 22;
   localparam logic [17:0]     RECIP20       = 18'd209716;

   // Gain register codes
   localparam logic [CODE_LOW_W-1:0]  CODE_LOW_0  = 2'd0;
   localparam logic [CODE_LOW_W-1:0]  CODE_LOW_1  = 2'd1;
   localparam logic [CODE_LOW_W-1:0]  CODE_LOW_2  = 2'd2;
   localparam logic [CODE_LOW_W-1:0]  CODE_LOW_3  = 2'd3;
   localparam logic [CODE_HIGH_W-1:0] CODE_HIGH_0 = 5'h00;
   localparam logic [CODE_HIGH_W-1:0] CODE_HIGH_4 = 5'h04;
   localparam logic [CODE_HIGH_W-1:0] CODE_HIGH_X = 5'h14;

   typedef struct packed {
      logic [COUNT_W-1:0] upper;
      logic [COUNT_W-1:0] lower;
      logic [COUNT_W-1:0] sat;
   } thresh_type;

   // Thresholds for one integration setting.
   // full  = min((n+1)*1024-1, 65535), upper = full - full/4,
   // lower = full*15/100 = full*3/20
   function automatic thresh_type calc_thresh(input logic [INTEG_W-1:0] integ);
      logic [17:0]        mant;
      logic [COUNT_W-1:0] full;
      logic [17:0]        triple;
      logic [35:0]        prod;
      thresh_type         t;
      mant    = {integ, 10'h3FF};
      full    = (integ > INTEG_LIMIT) ? {COUNT_W{1'b1}} : mant[COUNT_W-1:0];
      t.upper = full - {2'b00, full[COUNT_W-1:2]};
      triple  = {2'b00, full} + {1'b0, full, 1'b0};
      prod    = triple * RECIP20;
      t.lower = {2'b00, prod[35:RECIP20_SHIFT]};
      t.sat   = (integ > INTEG_LIMIT) ? full : t.upper;
      return t;
   endfunction

   function automatic logic [CODE_LOW_W-1:0] code_low(input logic [STEP_W-1:0] step);
      logic [CODE_LOW_W-1:0] c;
      unique case (step)
         3'd0, 3'd1:                   c = CODE_LOW_0;
         3'd2:                         c = CODE_LOW_1;
         3'd3:                         c = CODE_LOW_2;
         3'd4, 3'd5, 3'd6, 3'd7:       c = CODE_LOW_3;
      endcase
      return c;
   endfunction

   function automatic logic [CODE_HIGH_W-1:0] code_high(input logic [STEP_W-1:0] step);
      logic [CODE_HIGH_W-1:0] c;
      unique case (step)
         3'd0:                         c = CODE_HIGH_0;
         3'd1, 3'd2, 3'd3, 3'd4:       c = CODE_HIGH_4;
         3'd5, 3'd6, 3'd7:             c = CODE_HIGH_X;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/als_agr_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_agr_csr - integration setting and derived thresholds
// Works out the three count thresholds at reset and when the setting is
// written, and holds them in registers, so the sample path only compares.
// ----------------------------------------------------------------------------
module als_agr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [als_agr_pkg::INTEG_W-1:0]     csr_write_data,
   output als_agr_pkg::thresh_type             thresh
);
   import als_agr_pkg::*;

   thresh_type thresh_ff;
   thresh_type thresh_in;

   // Threshold update on reset or register write
   always_comb begin
      thresh_in = thresh_ff;
      if (reset) begin
         thresh_in = calc_thresh(INTEG_RESET);
      end else if (csr_write_en) begin
         thresh_in = calc_thresh(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      thresh_ff <= thresh_in;
   end

   assign thresh = thresh_ff;

`ifndef SYNTHESIS
   a_upper_above_lower: assert property (@(posedge clock) disable iff (reset)
      thresh_ff.upper > thresh_ff.lower)
      else $error("upper threshold not above lower threshold");

   a_sat_not_below_upper: assert property (@(posedge clock) disable iff (reset)
      thresh_ff.sat >= thresh_ff.upper)
      else $error("saturation threshold below upper threshold");
`endif

endmodule

// ===== rtl/als_agr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_agr_core - sample register, gain step update and result register
// One request enters the sample register per cycle unless req_stall is high; the
// step update and the code look-up happen on the move into the result register.
// ----------------------------------------------------------------------------
module als_agr_core #(
   parameter int GAIN_STEPS = als_agr_pkg::GAIN_STEPS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  als_agr_pkg::thresh_type                thresh,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [als_agr_pkg::COUNT_W-1:0]        req_clear_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_gain_changed,
   output logic [als_agr_pkg::STEP_W-1:0]         rsp_gain_step,
   output logic [als_agr_pkg::CODE_LOW_W-1:0]     rsp_gain_code_low,
   output logic [als_agr_pkg::CODE_HIGH_W-1:0]    rsp_gain_code_high,
   output logic                                   rsp_saturated
);
   import als_agr_pkg::*;

   localparam logic [STEP_W-1:0] MAX_STEP   = STEP_W'(GAIN_STEPS - 1);
   localparam logic [STEP_W-1:0] RESET_STEP =
      (GAIN_STEPS > RESET_STEP_NOMINAL) ? STEP_W'(RESET_STEP_NOMINAL)
                                        : STEP_W'(GAIN_STEPS - 1);

   // Sample register
   logic               s1_valid_ff, s1_valid_in;
   logic [COUNT_W-1:0] s1_count_ff, s1_count_in;

   // Gain state
   logic [STEP_W-1:0]  step_ff, step_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic [STEP_W-1:0]      rsp_step_ff, rsp_step_in;
   logic [CODE_LOW_W-1:0]  rsp_code_low_ff, rsp_code_low_in;
   logic [CODE_HIGH_W-1:0] rsp_code_high_ff, rsp_code_high_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   logic req_take;
   logic s1_move;
   logic over_upper;
   logic under_lower;
   logic [STEP_W-1:0] step_next;

   // Handshake: sample moves on when the result register is empty or emptying
   assign s1_move   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_move;
   assign req_take  = req_valid & ~req_stall;

   // Sample register next state
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_count_in = s1_count_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_count_in = req_clear_count;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (reset) begin
         s1_valid_in = 1'b0;
      end
   end

   // Threshold compares and one-step move, upper rule first
   assign over_upper  = s1_count_ff >= thresh.upper;
   assign under_lower = s1_count_ff <= thresh.lower;

   always_comb begin
      step_next = step_ff;
      priority if (over_upper && (step_ff != '0)) begin
         step_next = step_ff - STEP_W'(1);
      end else if (under_lower && (step_ff < MAX_STEP)) begin
         step_next = step_ff + STEP_W'(1);
      end else begin
         step_next = step_ff;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (reset) begin
         step_in = RESET_STEP;
      end else if (s1_move) begin
         step_in = step_next;
      end
   end

   // Result register next state
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_changed_in   = rsp_changed_ff;
      rsp_step_in      = rsp_step_ff;
      rsp_code_low_in  = rsp_code_low_ff;
      rsp_code_high_in = rsp_code_high_ff;
      rsp_sat_in       = rsp_sat_ff;
      if (s1_move) begin
         rsp_valid_in     = 1'b1;
         rsp_changed_in   = step_next != step_ff;
         rsp_step_in      = step_next;
         rsp_code_low_in  = code_low(step_next);
         rsp_code_high_in = code_high(step_next);
         rsp_sat_in       = s1_count_ff >= thresh.sat;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (reset) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_valid_ff      <= s1_valid_in;
      s1_count_ff      <= s1_count_in;
      step_ff          <= step_in;
      rsp_valid_ff     <= rsp_valid_in;
      rsp_changed_ff   <= rsp_changed_in;
      rsp_step_ff      <= rsp_step_in;
      rsp_code_low_ff  <= rsp_code_low_in;
      rsp_code_high_ff <= rsp_code_high_in;
      rsp_sat_ff       <= rsp_sat_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_gain_changed   = rsp_changed_ff;
   assign rsp_gain_step      = rsp_step_ff;
   assign rsp_gain_code_low  = rsp_code_low_ff;
   assign rsp_gain_code_high = rsp_code_high_ff;
   assign rsp_saturated      = rsp_sat_ff;

`ifndef SYNTHESIS
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= MAX_STEP)
      else $error("gain step beyond last step");

   a_move_loads_result: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (rsp_valid_ff && (rsp_step_ff == step_ff)))
      else $error("result register does not match gain state");

   a_step_moves_by_one: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (({1'b0, step_ff} == {1'b0, $past(step_ff)} + 4'd1) ||
                   ({1'b0, $past(step_ff)} == {1'b0, step_ff} + 4'd1) ||
                   ((step_ff == $past(step_ff)) && !rsp_changed_ff)))
      else $error("gain step moved by more than one or flag wrong");

   a_step_held_when_idle: assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(step_ff))
      else $error("gain step changed without a request");
`endif

endmodule

// ===== rtl/light_sensor_auto_gain_ranging.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sensor_auto_gain_ranging - clear channel automatic gain ranging
// Moves the sensor gain step by at most one per clear count sample and
// reports the step, its register codes and a saturation flag.
// ----------------------------------------------------------------------------
// One clear count request is taken per clock cycle while req_stall is low; it
// sits in the sample register, then the gain step update loads the result
// register. Sustained rate is one request per cycle unless the result side
// stalls; the result register and the sample register together let a new
// request in while a result waits. The gain step restarts at step 3 after
// reset (with default GAIN_STEPS). Writing the integration setting recomputes
// the registered thresholds; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module light_sensor_auto_gain_ranging #(
   parameter int GAIN_STEPS = als_agr_pkg::GAIN_STEPS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [als_agr_pkg::INTEG_W-1:0]        csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [als_agr_pkg::COUNT_W-1:0]        req_clear_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_gain_changed,
   output logic [als_agr_pkg::STEP_W-1:0]         rsp_gain_step,
   output logic [als_agr_pkg::CODE_LOW_W-1:0]     rsp_gain_code_low,
   output logic [als_agr_pkg::CODE_HIGH_W-1:0]    rsp_gain_code_high,
   output logic                                   rsp_saturated
);
   import als_agr_pkg::*;

   thresh_type thresh;

   // Setting and thresholds
   als_agr_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .thresh         (thresh)
   );

   // Sample path
   als_agr_core #(
      .GAIN_STEPS (GAIN_STEPS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .thresh             (thresh),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_clear_count    (req_clear_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_gain_changed   (rsp_gain_changed),
      .rsp_gain_step      (rsp_gain_step),
      .rsp_gain_code_low  (rsp_gain_code_low),
      .rsp_gain_code_high (rsp_gain_code_high),
      .rsp_saturated      (rsp_saturated)
   );

endmodule

// ===== tb/tb_light_sensor_auto_gain_ranging.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_light_sensor_auto_gain_ranging - gain ranging self-checking bench
// Drives clear count requests through the valid/stall handshake. A local
// model of the gain step and thresholds predicts every result, and each
// result is checked field by field. Runs directed edge cases first, then
// random phases over several integration settings with random idling,
// one long result hold-off, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_light_sensor_auto_gain_ranging;
   import als_agr_pkg::*;

   localparam int STEP_TOP         = GAIN_STEPS_DEFAULT - 1;
   localparam int START_STEP       = (RESET_STEP_NOMINAL < STEP_TOP) ?
                                     RESET_STEP_NOMINAL : STEP_TOP;
   localparam int COUNT_MAX        = (1 << COUNT_W) - 1;
   localparam int SETTLE_CYCLES    = 6;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int RANDOM_PHASES    = 8;
   localparam int PHASE_REQUESTS   = 60;

   typedef struct packed {
      logic                   changed;
      logic [STEP_W-1:0]      step;
      logic [CODE_LOW_W-1:0]  code_low;
      logic [CODE_HIGH_W-1:0] code_high;
      logic                   saturated;
   } gain_result_type;

   // Register codes per gain step; steps above five reuse the top codes
   localparam logic [CODE_LOW_W-1:0] STEP_CODE_LOW [8] = '{
      CODE_LOW_0, CODE_LOW_0, CODE_LOW_1, CODE_LOW_2,
      CODE_LOW_3, CODE_LOW_3, CODE_LOW_3, CODE_LOW_3};
   localparam logic [CODE_HIGH_W-1:0] STEP_CODE_HIGH [8] = '{
      CODE_HIGH_0, CODE_HIGH_4, CODE_HIGH_4, CODE_HIGH_4,
      CODE_HIGH_4, CODE_HIGH_X, CODE_HIGH_X, CODE_HIGH_X};

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [INTEG_W-1:0]     csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [COUNT_W-1:0]     req_clear_count;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_gain_changed;
   logic [STEP_W-1:0]      rsp_gain_step;
   logic [CODE_LOW_W-1:0]  rsp_gain_code_low;
   logic [CODE_HIGH_W-1:0] rsp_gain_code_high;
   logic                   rsp_saturated;

   // Local copy of the block state
   logic [INTEG_W-1:0]     model_integ;
   logic [STEP_W-1:0]      model_step;
   gain_result_type        expected_gains[$];

   int                     error_count;
   int                     requests_sent;
   int                     results_checked;
   int                     steps_moved;
   int                     saturations_seen;
   int                     settings_used;
   int                     input_stall_cycles;
   int                     quiet_cycles;

   // Idling controls; the result stall ones are shared with the receiver process
   bit                     req_gaps_on;
   bit                     rsp_stalls_on;
   bit                     long_hold_pending;

   light_sensor_auto_gain_ranging DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_clear_count    (req_clear_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_gain_changed   (rsp_gain_changed),
      .rsp_gain_step      (rsp_gain_step),
      .rsp_gain_code_low  (rsp_gain_code_low),
      .rsp_gain_code_high (rsp_gain_code_high),
      .rsp_saturated      (rsp_saturated)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Upper, lower and saturation levels for one integration setting
   function automatic void count_limits(input logic [INTEG_W-1:0] integ,
                                        output int upper, output int lower,
                                        output int sat_level);
      int full;
      full = (int'(integ) + 1) * 1024 - 1;
      if (full > COUNT_MAX) full = COUNT_MAX;
      upper     = full - full / 4;
      lower     = full * 15 / 100;
      sat_level = (integ <= INTEG_LIMIT) ? upper : full;
   endfunction

   // Next gain step and result for one accepted count; updates the model
   function automatic gain_result_type predict_gain(input logic [COUNT_W-1:0] count);
      int              upper;
      int              lower;
      int              sat_level;
      logic [STEP_W-1:0] next_step;
      gain_result_type r;
      count_limits(model_integ, upper, lower, sat_level);
      next_step = model_step;
      if (int'(count) >= upper && model_step > 0)
         next_step = model_step - 1'b1;
      else if (int'(count) <= lower && int'(model_step) < STEP_TOP)
         next_step = model_step + 1'b1;
      r.changed   = (next_step != model_step);
      r.step      = next_step;
      r.code_low  = STEP_CODE_LOW[next_step];
      r.code_high = STEP_CODE_HIGH[next_step];
      r.saturated = (int'(count) >= sat_level);
      model_step  = next_step;
      return r;
   endfunction

   // Random count, biased towards the thresholds so the step keeps moving
   function automatic logic [COUNT_W-1:0] pick_count();
      int upper;
      int lower;
      int sat_level;
      int v;
      count_limits(model_integ, upper, lower, sat_level);
      case ($urandom_range(0, 5))
         0:       v = upper + int'($urandom_range(0, 4)) - 2;
         1:       v = lower + int'($urandom_range(0, 4)) - 2;
         2:       v = sat_level + int'($urandom_range(0, 2)) - 1;
         3:       v = $urandom_range(0, lower);
         4:       v = $urandom_range(upper, COUNT_MAX);
         default: v = $urandom_range(0, COUNT_MAX);
      endcase
      if (v < 0) v = 0;
      if (v > COUNT_MAX) v = COUNT_MAX;
      return v[COUNT_W-1:0];
   endfunction

   // Send one clear count request; called and returns at a falling edge
   task automatic send_count(input logic [COUNT_W-1:0] count);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_clear_count <= count;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_gains.push_back(predict_gain(count));
      requests_sent++;
      @(negedge clock);
   endtask

   // Let every outstanding result arrive, then a few spare cycles
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (expected_gains.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_integration(input logic [INTEG_W-1:0] value);
      settle_pipeline();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      model_integ    = value;
      settings_used++;
   endtask

   // Reset setting: walk the step to both ends and probe each threshold edge
   task automatic test_reset_setting();
      int upper;
      int lower;
      int sat_level;
      count_limits(model_integ, upper, lower, sat_level);
      send_count(COUNT_W'(lower));
      send_count(COUNT_W'(lower + 1));
      send_count('0);
      send_count('0);               // held at the top step
      send_count(COUNT_W'(upper - 1));
      send_count(COUNT_W'(upper));
      repeat (4) send_count(COUNT_W'(COUNT_MAX));
      send_count(COUNT_W'(COUNT_MAX));   // held at the bottom step
   endtask

   // Shortest and longest integration, and the first capped setting
   task automatic test_integration_extremes();
      logic [INTEG_W-1:0] settings [3];
      int upper;
      int lower;
      int sat_level;
      settings = '{8'd0, 8'd255, INTEG_LIMIT + 8'd1};
      foreach (settings[i]) begin
         write_integration(settings[i]);
         count_limits(model_integ, upper, lower, sat_level);
         send_count(COUNT_W'(lower));
         send_count(COUNT_W'(upper));
         send_count(COUNT_W'(sat_level - 1));
         send_count(COUNT_W'(sat_level));
      end
   endtask

   // Random counts over several settings, idling switched in stretches
   task automatic test_random_ranging();
      logic [INTEG_W-1:0] integ;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       integ = 8'd255;
            1:       integ = 8'd0;
            2:       integ = INTEG_RESET;
            default: integ = INTEG_W'($urandom_range(0, 255));
         endcase
         write_integration(integ);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 20 == 0) begin
               req_gaps_on   = ($urandom_range(0, 3) != 0);
               rsp_stalls_on = ($urandom_range(0, 3) != 0);
            end
            send_count(pick_count());
         end
      end
   endtask

   // Long result hold-off while requests keep coming, so the input backs up
   task automatic test_result_backpressure();
      req_gaps_on       = 1'b0;
      rsp_stalls_on     = 1'b0;
      long_hold_pending = 1'b1;
      repeat (30) send_count(pick_count());
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_full_rate();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      write_integration(INTEG_W'($urandom_range(0, 255)));
      repeat (70) send_count(pick_count());
   endtask

   // Receiver: random stall bursts, plus the long hold when asked
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // Result checker against the oldest expectation
   always @(posedge clock) begin
      gain_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_gains.size() == 0) begin
            $error("unexpected result: step %0d", rsp_gain_step);
            error_count++;
         end else begin
            want = expected_gains.pop_front();
            results_checked++;
            if (want.changed) steps_moved++;
            if (want.saturated) saturations_seen++;
            if (rsp_gain_changed !== want.changed) begin
               $error("gain_changed: expected %0d, actual %0d",
                      want.changed, rsp_gain_changed);
               error_count++;
            end
            if (rsp_gain_step !== want.step) begin
               $error("gain_step: expected %0d, actual %0d", want.step, rsp_gain_step);
               error_count++;
            end
            if (rsp_gain_code_low !== want.code_low) begin
               $error("gain_code_low: expected %0d, actual %0d",
                      want.code_low, rsp_gain_code_low);
               error_count++;
            end
            if (rsp_gain_code_high !== want.code_high) begin
               $error("gain_code_high: expected %0d, actual %0d",
                      want.code_high, rsp_gain_code_high);
               error_count++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated: expected %0d, actual %0d",
                      want.saturated, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side; also counts input stall cycles
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) input_stall_cycles++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Sequence of tests
   initial begin
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_write_data     = '0;
      req_valid          = 1'b0;
      req_clear_count    = '0;
      model_integ        = INTEG_RESET;
      model_step         = START_STEP;
      error_count        = 0;
      requests_sent      = 0;
      results_checked    = 0;
      steps_moved        = 0;
      saturations_seen   = 0;
      settings_used      = 1;
      input_stall_cycles = 0;
      quiet_cycles       = 0;
      req_gaps_on        = 1'b0;
      rsp_stalls_on      = 1'b0;
      long_hold_pending  = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_reset_setting();
      test_integration_extremes();
      test_random_ranging();
      test_result_backpressure();
      test_full_rate();
      settle_pipeline();

      if (expected_gains.size() != 0) begin
         $error("%0d results never arrived", expected_gains.size());
         error_count++;
      end
      $display("Covered %0d requests and %0d results over %0d integration settings.",
               requests_sent, results_checked, settings_used);
      $display("Step moved %0d times, %0d saturated, input stalled %0d cycles.",
               steps_moved, saturations_seen, input_stall_cycles);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/als_agr_pkg.sv
rtl/als_agr_csr.sv
rtl/als_agr_core.sv
rtl/light_sensor_auto_gain_ranging.sv
tb/tb_light_sensor_auto_gain_ranging.sv
